>>> design/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

  localparam int BRB_DEPTH     = 1024;
  localparam int BRB_MAX_BURST = 64;

  localparam int ACTW = 3;
  localparam int DW   = 8;
  localparam int LENW = 7;
  localparam int GW   = 11;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 64;

  typedef enum logic [ACTW-1:0] {
    ACT_ENQ    = 3'd0,
    ACT_DEQ    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_SKIP   = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_STATUS = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [ACTW-1:0] action;
    logic [DW-1:0]   data_in;
    logic            chunk_end;
    logic [LENW-1:0] length;
  } item_t;

  typedef struct packed {
    logic [DW-1:0] data_out;
    logic          has_data;
    logic          last;
    logic [GW-1:0] granted;
    logic [GW-1:0] used_bytes;
    logic [GW-1:0] free_bytes;
    logic [GW-1:0] contiguous_write;
    logic [GW-1:0] contiguous_read;
  } result_t;

endpackage

>>> design/brb_ram.sv
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/brb_oreg.sv
`timescale 1ns / 1ps

module brb_oreg import brb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> design/brb_ctrl.sv
`timescale 1ns / 1ps

module brb_ctrl import brb_pkg::*; #(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BURST = BRB_MAX_BURST
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  item_t                    item_i,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [DW-1:0]            ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [DW-1:0]            ram_rdata_i,
  input  logic                     out_free_i,
  output logic                     out_load_o,
  output result_t                  out_res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int XW = (CW > LENW) ? CW : LENW;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [CW-1:0] by);
    logic [CW:0] sum;
    sum = (CW+1)'(idx) + (CW+1)'(by);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e        state_q, state_d;
  item_t         item_q, item_d;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] rear_q, rear_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [GW-1:0] chunk_q, chunk_d;
  logic [GW-1:0] gr_q, gr_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [BW-1:0] cnt_q, cnt_d;

  action_e       act;
  logic [XW-1:0] len_x, fill_x, min_x;
  logic [CW-1:0] skip_n;
  logic [BW-1:0] burst_n;
  logic [GW-1:0] chunk_inc;
  logic [CW-1:0] free_c, end_w, end_r;

  assign act       = action_e'(item_q.action);
  assign len_x     = XW'(item_q.length);
  assign fill_x    = XW'(fill_q);
  assign min_x     = (len_x < fill_x) ? len_x : fill_x;
  assign skip_n    = CW'(min_x);
  assign burst_n   = (min_x > XW'(MAX_BURST)) ? BW'(MAX_BURST) : BW'(min_x);
  assign chunk_inc = (chunk_q == '1) ? chunk_q : chunk_q + GW'(1);
  assign free_c    = CW'(DEPTH) - fill_q;
  assign end_w     = CW'(DEPTH) - CW'(rear_q);
  assign end_r     = CW'(DEPTH) - CW'(front_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((act == ACT_DEQ || act == ACT_PEEK) && burst_n != '0) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free_i && cnt_q == BW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_d      = item_q;
    front_d     = front_q;
    rear_d      = rear_q;
    fill_d      = fill_q;
    chunk_d     = chunk_q;
    gr_d        = gr_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = rear_q;
    ram_wdata_o = item_q.data_in;
    ram_re_o    = 1'b0;
    ram_raddr_o = front_q;
    out_load_o  = 1'b0;

    out_res_o.data_out         = '0;
    out_res_o.has_data         = 1'b0;
    out_res_o.last             = 1'b1;
    out_res_o.granted          = gr_q;
    out_res_o.used_bytes       = GW'(fill_q);
    out_res_o.free_bytes       = GW'(free_c);
    out_res_o.contiguous_write = GW'((free_c < end_w) ? free_c : end_w);
    out_res_o.contiguous_read  = GW'((fill_q < end_r) ? fill_q : end_r);

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d = item_i;
        end
      end
      ST_EXEC: begin
        case (act)
          ACT_ENQ: begin
            gr_d = chunk_q;
            if (fill_q != CW'(DEPTH)) begin
              ram_we_o = 1'b1;
              rear_d   = adv(rear_q, CW'(1));
              fill_d   = fill_q + CW'(1);
              gr_d     = chunk_inc;
            end
            chunk_d = item_q.chunk_end ? '0 : gr_d;
          end
          ACT_DEQ, ACT_PEEK: begin
            gr_d     = GW'(burst_n);
            ram_re_o = burst_n != '0;
            pos_d    = adv(front_q, CW'(1));
            cnt_d    = burst_n;
            if (act == ACT_DEQ) begin
              front_d = adv(front_q, CW'(burst_n));
              fill_d  = fill_q - CW'(burst_n);
            end
          end
          ACT_SKIP: begin
            gr_d    = GW'(skip_n);
            front_d = adv(front_q, skip_n);
            fill_d  = fill_q - skip_n;
          end
          ACT_CLEAR: begin
            gr_d    = '0;
            front_d = '0;
            rear_d  = '0;
            fill_d  = '0;
          end
          default: begin
            gr_d = '0;
          end
        endcase
      end
      ST_RESP: begin
        out_load_o = out_free_i;
      end
      ST_READ: begin
        out_load_o         = out_free_i;
        out_res_o.data_out = ram_rdata_i;
        out_res_o.has_data = 1'b1;
        out_res_o.last     = cnt_q == BW'(1);
        ram_raddr_o        = pos_q;
        if (out_free_i && cnt_q != BW'(1)) begin
          ram_re_o = 1'b1;
          pos_d    = adv(pos_q, CW'(1));
          cnt_d    = cnt_q - BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign item_ready_o = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      rear_q  <= '0;
      fill_q  <= '0;
      chunk_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      fill_q  <= fill_d;
      chunk_q <= chunk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    gr_q   <= gr_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i)
    else $error("result loaded into a busy output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv(front_q, fill_q) == rear_q)
    else $error("front, fill and rear out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> cnt_q != '0)
    else $error("burst running with no bytes left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_o |=> state_q == ST_EXEC)
    else $error("accepted item not executed");

endmodule

>>> design/byte_ring_buffer.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields
// s_axis    in   tdata: action[2:0] data_in[10:3] length[17:11]; tlast: chunk_end
// m_axis    out  tdata: data_out, granted, used, free, contig write, contig read;
//                tuser: has_data; tlast: last
//
// Enqueue, skip, clear and status go through accept, execute and result for each item.
// Dequeue and peek of n bytes send a burst after accept and execute; the store
// read port gives one byte per cycle while m_axis_tready stays high.
// Reset zeroes the pointers, fill and chunk count; store contents stay undefined.
// A stalled output holds the burst; one result waits in the output register
// while the next item is taken.

module byte_ring_buffer import brb_pkg::*; #(
  parameter int DEPTH     = BRB_DEPTH,
  parameter int MAX_BURST = BRB_MAX_BURST
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action, data_in, length
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // data_out, granted, used_bytes, free_bytes, contiguous_write, contiguous_read
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // has_data
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);

  item_t         item;
  result_t       res_c, res_o;
  logic          ram_we, ram_re, out_load, out_free;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  assign item.action    = s_axis_tdata[2:0];
  assign item.data_in   = s_axis_tdata[10:3];
  assign item.length    = s_axis_tdata[17:11];
  assign item.chunk_end = s_axis_tlast;

  brb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .out_res_o    (res_c)
  );

  brb_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brb_oreg u_oreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (res_c),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_o)
  );

  assign m_axis_tdata = {1'b0, res_o.contiguous_read, res_o.contiguous_write,
                         res_o.free_bytes, res_o.used_bytes, res_o.granted,
                         res_o.data_out};
  assign m_axis_tuser = res_o.has_data;
  assign m_axis_tlast = res_o.last;

endmodule
